// ===== hdl/cma_pkg.sv =====
package cma_pkg;

  localparam int FUNC_W     = 2;
  localparam int CHAN_W     = 10;
  localparam int FIELD_W    = 18;
  localparam int IN_DATA_W  = 88;
  localparam int CACC_W     = 48;
  localparam int TACC_W     = 60;
  localparam int OUT_DATA_W = 240;

  typedef enum logic [FUNC_W-1:0] {
    FN_ACC = 2'd0,
    FN_RDC = 2'd1,
    FN_RDT = 2'd2
  } func_t;

  typedef struct packed {
    logic acc;
    logic rdc;
    logic rdt;
    logic hit;
  } ctl_t;

endpackage

// ===== hdl/cma_ram.sv =====
module cma_ram #(
  parameter int WIDTH = 192,
  parameter int DEPTH = 1024,
  localparam int AW = $clog2(DEPTH)
) (
  input  logic             clk,
  input  logic             we,
  input  logic [AW-1:0]    waddr,
  input  logic [WIDTH-1:0] wdata,
  input  logic             re,
  input  logic [AW-1:0]    raddr,
  output logic [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata_r <= mem[raddr];
    end
  end

  assign rdata = rdata_r;

endmodule

// ===== hdl/cma_sat.sv =====
module cma_sat #(
  parameter int ACC_W  = 48,
  parameter int TERM_W = 37,
  parameter bit UNS    = 1'b0
) (
  input  logic [ACC_W-1:0]         acc,
  input  logic signed [TERM_W-1:0] term,
  output logic [ACC_W-1:0]         sum
);

  localparam int SW = ((ACC_W > TERM_W) ? ACC_W : TERM_W) + 2;

  logic signed [SW-1:0] acc_x;
  logic signed [SW-1:0] term_x;
  logic signed [SW-1:0] sum_x;
  logic signed [SW-1:0] hi_x;
  logic signed [SW-1:0] lo_x;
  logic signed [SW-1:0] smax_x;

  always_comb begin
    smax_x = $signed(SW'({1'b0, {(ACC_W-1){1'b1}}}));
    if (UNS) begin
      acc_x = $signed(SW'(acc));
      hi_x  = $signed(SW'({ACC_W{1'b1}}));
      lo_x  = '0;
    end else begin
      acc_x = SW'($signed(acc));
      hi_x  = smax_x;
      lo_x  = ~smax_x;
    end
    term_x = SW'(term);
    sum_x  = acc_x + term_x;
    if (sum_x > hi_x) begin
      sum = hi_x[ACC_W-1:0];
    end else if (sum_x < lo_x) begin
      sum = lo_x[ACC_W-1:0];
    end else begin
      sum = sum_x[ACC_W-1:0];
    end
  end

endmodule

// ===== hdl/cma_prod.sv =====
module cma_prod #(
  parameter int SAMPLE_BITS = 18,
  localparam int TW = 2*SAMPLE_BITS + 1
) (
  input  logic                                clk,
  input  logic                                en,
  input  logic signed [cma_pkg::FIELD_W-1:0]  a_re,
  input  logic signed [cma_pkg::FIELD_W-1:0]  a_im,
  input  logic signed [cma_pkg::FIELD_W-1:0]  b_re,
  input  logic signed [cma_pkg::FIELD_W-1:0]  b_im,
  output logic signed [TW-1:0]                pa,
  output logic signed [TW-1:0]                pb,
  output logic signed [TW-1:0]                cr,
  output logic signed [TW-1:0]                ci
);

  import cma_pkg::*;

  localparam int SB = SAMPLE_BITS;
  localparam int PW = 2*SAMPLE_BITS;

  logic signed [SB-1:0] ar, ai, br, bi;
  logic signed [PW-1:0] p_arar_r, p_aiai_r, p_brbr_r, p_bibi_r;
  logic signed [PW-1:0] p_arbr_r, p_aibi_r, p_aibr_r, p_arbi_r;
  logic signed [TW-1:0] pa_r, pb_r, cr_r, ci_r;

  assign ar = SB'(a_re);
  assign ai = SB'(a_im);
  assign br = SB'(b_re);
  assign bi = SB'(b_im);

  always_ff @(posedge clk) begin
    if (en) begin
      p_arar_r <= PW'(ar) * PW'(ar);
      p_aiai_r <= PW'(ai) * PW'(ai);
      p_brbr_r <= PW'(br) * PW'(br);
      p_bibi_r <= PW'(bi) * PW'(bi);
      p_arbr_r <= PW'(ar) * PW'(br);
      p_aibi_r <= PW'(ai) * PW'(bi);
      p_aibr_r <= PW'(ai) * PW'(br);
      p_arbi_r <= PW'(ar) * PW'(bi);
      pa_r     <= TW'(p_arar_r) + TW'(p_aiai_r);
      pb_r     <= TW'(p_brbr_r) + TW'(p_bibi_r);
      cr_r     <= TW'(p_arbr_r) + TW'(p_aibi_r);
      ci_r     <= TW'(p_aibr_r) - TW'(p_arbi_r);
    end
  end

  assign pa = pa_r;
  assign pb = pb_r;
  assign cr = cr_r;
  assign ci = ci_r;

endmodule

// ===== hdl/cross_multiply_accumulate.sv =====
// An accepted item passes registers s1, s2, s3 and the output register.
// Throughput: one item per cycle unless the output stalls; the per-channel
// sums live in one read-modify-write RAM with forwarding, so repeated
// channels do not stall. Reset: totals and control clear at once; then a
// clearing pass zeroes every RAM entry, with in_tready low throughout.
module cross_multiply_accumulate #(
  parameter int CHANNELS    = 1024,
  parameter int SAMPLE_BITS = 18
) (
  input  logic                                clk,
  input  logic                                rst_n,
  input  logic                                in_tvalid,
  output logic                                in_tready,
  // chan, a_re, a_im, b_re, b_im, zero pad
  input  logic [cma_pkg::IN_DATA_W-1:0]       in_tdata,
  // func
  input  logic [cma_pkg::FUNC_W-1:0]          in_tuser,
  output logic                                out_tvalid,
  input  logic                                out_tready,
  // power_a, power_b, cross_re, cross_im
  output logic [cma_pkg::OUT_DATA_W-1:0]      out_tdata,
  // is_totals
  output logic [0:0]                          out_tuser
);

  import cma_pkg::*;

  localparam int AW  = $clog2(CHANNELS);
  localparam int AXW = AW + CHAN_W;
  localparam int TW  = 2*SAMPLE_BITS + 1;
  localparam int MW  = 4*CACC_W;

  logic                en;
  logic                clr_busy_r, clr_busy_nxt;
  logic [AW-1:0]       clr_addr_r, clr_addr_nxt;

  logic [CHAN_W-1:0]   in_chan;
  logic [AXW-1:0]      in_chan_x;
  logic                chan_ok;
  ctl_t                in_ctl;

  ctl_t                s1_ctl_r, s2_ctl_r, s3_ctl_r;
  logic [AW-1:0]       s1_addr_r, s2_addr_r, s3_addr_r;
  logic signed [FIELD_W-1:0] s1_are_r, s1_aim_r, s1_bre_r, s1_bim_r;

  logic signed [TW-1:0] t_pa, t_pb, t_cr, t_ci;

  logic                ram_we;
  logic [AW-1:0]       ram_waddr;
  logic [MW-1:0]       ram_wdata;
  logic [MW-1:0]       ram_rdata;

  logic [MW-1:0]       acc_r, acc_nxt;
  logic                lw_vld_r;
  logic [AW-1:0]       lw_addr_r;
  logic [MW-1:0]       lw_data_r;

  logic                s3_wr;
  logic [MW-1:0]       s3_wdata;
  logic [CACC_W-1:0]   c_pa, c_pb, c_cr, c_ci;

  logic [TACC_W-1:0]   tot_pa_r, tot_pb_r, tot_cr_r, tot_ci_r;
  logic [TACC_W-1:0]   tot_pa_nxt, tot_pb_nxt, tot_cr_nxt, tot_ci_nxt;
  logic [TACC_W-1:0]   ts_pa, ts_pb, ts_cr, ts_ci;

  logic                out_tvalid_r;
  logic [0:0]          out_tuser_r;
  logic [OUT_DATA_W-1:0] out_tdata_r, out_tdata_nxt;

  assign en        = !out_tvalid_r || out_tready;
  assign in_tready = en && !clr_busy_r;

  // clearing pass
  always_comb begin
    clr_busy_nxt = clr_busy_r;
    clr_addr_nxt = clr_addr_r;
    if (clr_busy_r) begin
      if (clr_addr_r == AW'(CHANNELS - 1)) begin
        clr_busy_nxt = 1'b0;
      end else begin
        clr_addr_nxt = clr_addr_r + 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      clr_busy_r <= 1'b1;
      clr_addr_r <= '0;
    end else begin
      clr_busy_r <= clr_busy_nxt;
      clr_addr_r <= clr_addr_nxt;
    end
  end

  // decode
  assign in_chan   = in_tdata[CHAN_W-1:0];
  assign in_chan_x = AXW'(in_chan);
  assign chan_ok   = 32'(in_chan) < 32'(CHANNELS);

  always_comb begin
    in_ctl = '0;
    if (in_tvalid && in_tready) begin
      case (in_tuser)
        FN_ACC: in_ctl.acc = chan_ok && (in_chan != '0);
        FN_RDC: begin
          in_ctl.rdc = 1'b1;
          in_ctl.hit = chan_ok;
        end
        FN_RDT: in_ctl.rdt = 1'b1;
        default: in_ctl = '0;
      endcase
    end
  end

  // pipeline control
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_ctl_r <= '0;
      s2_ctl_r <= '0;
      s3_ctl_r <= '0;
      lw_vld_r <= 1'b0;
    end else if (en) begin
      s1_ctl_r <= in_ctl;
      s2_ctl_r <= s1_ctl_r;
      s3_ctl_r <= s2_ctl_r;
      lw_vld_r <= s3_wr;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      s1_addr_r <= in_chan_x[AW-1:0];
      s1_are_r  <= $signed(in_tdata[CHAN_W +: FIELD_W]);
      s1_aim_r  <= $signed(in_tdata[CHAN_W + FIELD_W +: FIELD_W]);
      s1_bre_r  <= $signed(in_tdata[CHAN_W + 2*FIELD_W +: FIELD_W]);
      s1_bim_r  <= $signed(in_tdata[CHAN_W + 3*FIELD_W +: FIELD_W]);
      s2_addr_r <= s1_addr_r;
      s3_addr_r <= s2_addr_r;
      acc_r     <= acc_nxt;
      lw_addr_r <= s3_addr_r;
      lw_data_r <= s3_wdata;
    end
  end

  cma_prod #(
    .SAMPLE_BITS(SAMPLE_BITS)
  ) u_prod (
    .clk (clk),
    .en  (en),
    .a_re(s1_are_r),
    .a_im(s1_aim_r),
    .b_re(s1_bre_r),
    .b_im(s1_bim_r),
    .pa  (t_pa),
    .pb  (t_pb),
    .cr  (t_cr),
    .ci  (t_ci)
  );

  cma_ram #(
    .WIDTH(MW),
    .DEPTH(CHANNELS)
  ) u_ram (
    .clk  (clk),
    .we   (ram_we),
    .waddr(ram_waddr),
    .wdata(ram_wdata),
    .re   (en),
    .raddr(s1_addr_r),
    .rdata(ram_rdata)
  );

  // forward writes the RAM read missed
  always_comb begin
    if (s3_wr && (s3_addr_r == s2_addr_r)) begin
      acc_nxt = s3_wdata;
    end else if (lw_vld_r && (lw_addr_r == s2_addr_r)) begin
      acc_nxt = lw_data_r;
    end else begin
      acc_nxt = ram_rdata;
    end
  end

  cma_sat #(.ACC_W(CACC_W), .TERM_W(TW), .UNS(1'b1)) u_sat_cpa (
    .acc(acc_r[0 +: CACC_W]), .term(t_pa), .sum(c_pa));
  cma_sat #(.ACC_W(CACC_W), .TERM_W(TW), .UNS(1'b1)) u_sat_cpb (
    .acc(acc_r[CACC_W +: CACC_W]), .term(t_pb), .sum(c_pb));
  cma_sat #(.ACC_W(CACC_W), .TERM_W(TW), .UNS(1'b0)) u_sat_ccr (
    .acc(acc_r[2*CACC_W +: CACC_W]), .term(t_cr), .sum(c_cr));
  cma_sat #(.ACC_W(CACC_W), .TERM_W(TW), .UNS(1'b0)) u_sat_cci (
    .acc(acc_r[3*CACC_W +: CACC_W]), .term(t_ci), .sum(c_ci));

  cma_sat #(.ACC_W(TACC_W), .TERM_W(TW), .UNS(1'b1)) u_sat_tpa (
    .acc(tot_pa_r), .term(t_pa), .sum(ts_pa));
  cma_sat #(.ACC_W(TACC_W), .TERM_W(TW), .UNS(1'b1)) u_sat_tpb (
    .acc(tot_pb_r), .term(t_pb), .sum(ts_pb));
  cma_sat #(.ACC_W(TACC_W), .TERM_W(TW), .UNS(1'b0)) u_sat_tcr (
    .acc(tot_cr_r), .term(t_cr), .sum(ts_cr));
  cma_sat #(.ACC_W(TACC_W), .TERM_W(TW), .UNS(1'b0)) u_sat_tci (
    .acc(tot_ci_r), .term(t_ci), .sum(ts_ci));

  assign s3_wr    = s3_ctl_r.acc || (s3_ctl_r.rdc && s3_ctl_r.hit);
  assign s3_wdata = s3_ctl_r.acc ? {c_ci, c_cr, c_pb, c_pa} : '0;

  assign ram_we    = clr_busy_r || (en && s3_wr);
  assign ram_waddr = clr_busy_r ? clr_addr_r : s3_addr_r;
  assign ram_wdata = clr_busy_r ? '0 : s3_wdata;

  // band totals
  always_comb begin
    tot_pa_nxt = tot_pa_r;
    tot_pb_nxt = tot_pb_r;
    tot_cr_nxt = tot_cr_r;
    tot_ci_nxt = tot_ci_r;
    if (en && s3_ctl_r.acc) begin
      tot_pa_nxt = ts_pa;
      tot_pb_nxt = ts_pb;
      tot_cr_nxt = ts_cr;
      tot_ci_nxt = ts_ci;
    end else if (en && s3_ctl_r.rdt) begin
      tot_pa_nxt = '0;
      tot_pb_nxt = '0;
      tot_cr_nxt = '0;
      tot_ci_nxt = '0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      tot_pa_r <= '0;
      tot_pb_r <= '0;
      tot_cr_r <= '0;
      tot_ci_r <= '0;
    end else begin
      tot_pa_r <= tot_pa_nxt;
      tot_pb_r <= tot_pb_nxt;
      tot_cr_r <= tot_cr_nxt;
      tot_ci_r <= tot_ci_nxt;
    end
  end

  // output register
  always_comb begin
    if (s3_ctl_r.rdt) begin
      out_tdata_nxt = {tot_ci_r, tot_cr_r, tot_pb_r, tot_pa_r};
    end else if (s3_ctl_r.hit) begin
      out_tdata_nxt = {TACC_W'($signed(acc_r[3*CACC_W +: CACC_W])),
                       TACC_W'($signed(acc_r[2*CACC_W +: CACC_W])),
                       TACC_W'(acc_r[CACC_W +: CACC_W]),
                       TACC_W'(acc_r[0 +: CACC_W])};
    end else begin
      out_tdata_nxt = '0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_tvalid_r <= 1'b0;
    end else if (en) begin
      out_tvalid_r <= s3_ctl_r.rdc || s3_ctl_r.rdt;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      out_tuser_r <= s3_ctl_r.rdt;
      out_tdata_r <= out_tdata_nxt;
    end
  end

  assign out_tvalid = out_tvalid_r;
  assign out_tuser  = out_tuser_r;
  assign out_tdata  = out_tdata_r;

`ifndef ASSERT_OFF
  a_no_accept_in_clear: assert property (@(posedge clk) disable iff (!rst_n)
    clr_busy_r |-> !(in_tvalid && in_tready))
    else $error("item accepted during clearing pass");

  a_no_item_write_in_clear: assert property (@(posedge clk) disable iff (!rst_n)
    clr_busy_r |-> !s3_wr)
    else $error("item write collides with clearing pass");

  a_one_op_per_stage: assert property (@(posedge clk) disable iff (!rst_n)
    $onehot0({s3_ctl_r.acc, s3_ctl_r.rdc, s3_ctl_r.rdt}))
    else $error("stage carries more than one operation");

  a_totals_cleared: assert property (@(posedge clk) disable iff (!rst_n)
    (en && s3_ctl_r.rdt) |=> (tot_pa_r == '0 && tot_pb_r == '0 &&
                               tot_cr_r == '0 && tot_ci_r == '0))
    else $error("totals not cleared after read");
`endif

endmodule

// ===== tb/cross_multiply_accumulate_tb.sv =====
`timescale 1ns / 1ps

module cross_multiply_accumulate_tb;
  import cma_pkg::*;

  localparam int CHANNELS = 1024;
  localparam int RANDOM_ITEMS = 900;
  localparam int SAT_ROUNDS = 40;
  localparam int WATCHDOG_LIMIT = 4000;
  localparam int CALM_LEVEL = 150;
  localparam int LONG_HOLD = 300;
  localparam int LONG_HOLD_AFTER = 80;
  localparam int MAX_REPORTS = 10;

  localparam logic [FUNC_W-1:0] FN_UNUSED = 2'd3;

  localparam logic signed [FIELD_W-1:0] S_MAX = 18'h1FFFF;
  localparam logic signed [FIELD_W-1:0] S_MIN = 18'h20000;

  localparam longint CH_UMAX = 64'h0000_FFFF_FFFF_FFFF;
  localparam longint CH_SMAX = 64'h0000_7FFF_FFFF_FFFF;
  localparam longint CH_SMIN = -CH_SMAX - 1;
  localparam longint TOT_UMAX = 64'h0FFF_FFFF_FFFF_FFFF;
  localparam longint TOT_SMAX = 64'h07FF_FFFF_FFFF_FFFF;
  localparam longint TOT_SMIN = -TOT_SMAX - 1;

  typedef struct {
    logic [FUNC_W-1:0]         func;
    logic [CHAN_W-1:0]         chan;
    logic signed [FIELD_W-1:0] a_re;
    logic signed [FIELD_W-1:0] a_im;
    logic signed [FIELD_W-1:0] b_re;
    logic signed [FIELD_W-1:0] b_im;
    bit                        hold;
  } spectrum_item_t;

  typedef struct packed {
    logic              is_tot;
    logic [TACC_W-1:0] pa;
    logic [TACC_W-1:0] pb;
    logic [TACC_W-1:0] cr;
    logic [TACC_W-1:0] ci;
  } sums_t;

  logic                  clk = 1'b0;
  logic                  rst_n = 1'b0;
  logic                  in_tvalid = 1'b0;
  logic                  in_tready;
  logic [IN_DATA_W-1:0]  in_tdata = '0;
  logic [FUNC_W-1:0]     in_tuser = '0;
  logic                  out_tvalid;
  logic                  out_tready = 1'b0;
  logic [OUT_DATA_W-1:0] out_tdata;
  logic [0:0]            out_tuser;

  spectrum_item_t spectra_q[$];
  sums_t          sums_due[$];
  spectrum_item_t cur_item;
  spectrum_item_t nxt_item;
  sums_t          got;
  sums_t          want;

  longint ch_pa [CHANNELS] = '{default: 0};
  longint ch_pb [CHANNELS] = '{default: 0};
  longint ch_cr [CHANNELS] = '{default: 0};
  longint ch_ci [CHANNELS] = '{default: 0};
  longint tot_pa = 0;
  longint tot_pb = 0;
  longint tot_cr = 0;
  longint tot_ci = 0;

  int items_total = 0;
  int items_taken = 0;
  int sums_seen = 0;
  int faults = 0;
  int gap_left = 0;
  int hold_left = 0;
  int stall_cycles = 0;
  bit long_hold_done = 1'b0;

  cross_multiply_accumulate #(
    .CHANNELS   (CHANNELS),
    .SAMPLE_BITS(FIELD_W)
  ) u_top (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_tvalid (in_tvalid),
    .in_tready (in_tready),
    .in_tdata  (in_tdata),
    .in_tuser  (in_tuser),
    .out_tvalid(out_tvalid),
    .out_tready(out_tready),
    .out_tdata (out_tdata),
    .out_tuser (out_tuser)
  );

  always #6 clk = ~clk;

  function automatic longint sat_add(longint acc, longint v, longint lo, longint hi);
    longint s;
    s = acc + v;
    if (s > hi) return hi;
    if (s < lo) return lo;
    return s;
  endfunction

  function automatic void accumulate_spectra(spectrum_item_t it);
    longint ar, ai, br, bi, pa, pb, cr, ci;
    sums_t  res;
    int     c;
    c = it.chan;
    ar = it.a_re;
    ai = it.a_im;
    br = it.b_re;
    bi = it.b_im;
    case (it.func)
      FN_ACC: begin
        if (c == 0 || c >= CHANNELS) return;
        pa = ar * ar + ai * ai;
        pb = br * br + bi * bi;
        cr = ar * br + ai * bi;
        ci = ai * br - ar * bi;
        ch_pa[c] = sat_add(ch_pa[c], pa, 0, CH_UMAX);
        ch_pb[c] = sat_add(ch_pb[c], pb, 0, CH_UMAX);
        ch_cr[c] = sat_add(ch_cr[c], cr, CH_SMIN, CH_SMAX);
        ch_ci[c] = sat_add(ch_ci[c], ci, CH_SMIN, CH_SMAX);
        tot_pa = sat_add(tot_pa, pa, 0, TOT_UMAX);
        tot_pb = sat_add(tot_pb, pb, 0, TOT_UMAX);
        tot_cr = sat_add(tot_cr, cr, TOT_SMIN, TOT_SMAX);
        tot_ci = sat_add(tot_ci, ci, TOT_SMIN, TOT_SMAX);
      end
      FN_RDC: begin
        res = '0;
        if (c < CHANNELS) begin
          res.pa = TACC_W'(ch_pa[c]);
          res.pb = TACC_W'(ch_pb[c]);
          res.cr = TACC_W'(ch_cr[c]);
          res.ci = TACC_W'(ch_ci[c]);
          ch_pa[c] = 0;
          ch_pb[c] = 0;
          ch_cr[c] = 0;
          ch_ci[c] = 0;
        end
        sums_due.push_back(res);
      end
      FN_RDT: begin
        res.is_tot = 1'b1;
        res.pa = TACC_W'(tot_pa);
        res.pb = TACC_W'(tot_pb);
        res.cr = TACC_W'(tot_cr);
        res.ci = TACC_W'(tot_ci);
        tot_pa = 0;
        tot_pb = 0;
        tot_cr = 0;
        tot_ci = 0;
        sums_due.push_back(res);
      end
      default: ;
    endcase
  endfunction

  function automatic void queue_item(logic [FUNC_W-1:0] f, int c,
                                     logic signed [FIELD_W-1:0] ar,
                                     logic signed [FIELD_W-1:0] ai,
                                     logic signed [FIELD_W-1:0] br,
                                     logic signed [FIELD_W-1:0] bi, bit hold);
    spectrum_item_t it;
    it.func = f;
    it.chan = CHAN_W'(c);
    it.a_re = ar;
    it.a_im = ai;
    it.b_re = br;
    it.b_im = bi;
    it.hold = hold;
    spectra_q.push_back(it);
    items_total++;
  endfunction

  function automatic logic signed [FIELD_W-1:0] rand_sample();
    case ($urandom_range(0, 15))
      0: return S_MIN;
      1: return S_MAX;
      2: return '0;
      default: return FIELD_W'($urandom);
    endcase
  endfunction

  function automatic void report_fault(string msg);
    faults++;
    if (faults <= MAX_REPORTS) $display("%s", msg);
  endfunction

  always @(posedge clk) begin
    if (!rst_n) begin
      in_tvalid <= 1'b0;
      gap_left <= 0;
    end else begin
      if (in_tvalid && in_tready) begin
        accumulate_spectra(cur_item);
        items_taken++;
      end
      if (!in_tvalid || in_tready) begin
        if (gap_left != 0) begin
          gap_left <= gap_left - 1;
          in_tvalid <= 1'b0;
        end else if (spectra_q.size() >= CALM_LEVEL && $urandom_range(0, 9) == 0) begin
          gap_left <= $urandom_range(0, 12);
          in_tvalid <= 1'b0;
        end else if (spectra_q.size() != 0 && (!spectra_q[0].hold || sums_due.size() == 0)) begin
          nxt_item = spectra_q.pop_front();
          cur_item <= nxt_item;
          in_tvalid <= 1'b1;
          in_tuser <= nxt_item.func;
          in_tdata <= {{(IN_DATA_W - CHAN_W - 4 * FIELD_W){1'b0}},
                       nxt_item.b_im, nxt_item.b_re, nxt_item.a_im, nxt_item.a_re,
                       nxt_item.chan};
        end else begin
          in_tvalid <= 1'b0;
        end
      end
    end
  end

  always @(posedge clk) begin
    if (!rst_n) begin
      out_tready <= 1'b0;
      hold_left <= 0;
    end else if (hold_left != 0) begin
      hold_left <= hold_left - 1;
      out_tready <= 1'b0;
    end else if (!long_hold_done && sums_seen >= LONG_HOLD_AFTER) begin
      long_hold_done <= 1'b1;
      hold_left <= LONG_HOLD - 1;
      out_tready <= 1'b0;
    end else if (spectra_q.size() >= CALM_LEVEL && $urandom_range(0, 9) == 0) begin
      hold_left <= $urandom_range(0, 12);
      out_tready <= 1'b0;
    end else begin
      out_tready <= 1'b1;
    end
  end

  always @(posedge clk) begin
    if (rst_n && out_tvalid && out_tready) begin
      got.is_tot = out_tuser[0];
      got.pa = out_tdata[TACC_W-1:0];
      got.pb = out_tdata[2*TACC_W-1:TACC_W];
      got.cr = out_tdata[3*TACC_W-1:2*TACC_W];
      got.ci = out_tdata[4*TACC_W-1:3*TACC_W];
      sums_seen <= sums_seen + 1;
      if (sums_due.size() == 0) begin
        report_fault($sformatf("unexpected result: tot=%0b pa=%h pb=%h cr=%h ci=%h",
                               got.is_tot, got.pa, got.pb, got.cr, got.ci));
      end else begin
        want = sums_due.pop_front();
        if (got.is_tot !== want.is_tot || got.pa !== want.pa || got.pb !== want.pb ||
            got.cr !== want.cr || got.ci !== want.ci) begin
          report_fault($sformatf({"mismatch #%0d: expected tot=%0b pa=%h pb=%h cr=%h ci=%h",
                                  " got tot=%0b pa=%h pb=%h cr=%h ci=%h"},
                                 sums_seen, want.is_tot, want.pa, want.pb, want.cr,
                                 want.ci, got.is_tot, got.pa, got.pb, got.cr, got.ci));
        end
      end
    end
  end

  always @(posedge clk) begin
    if ((in_tvalid && in_tready) || (out_tvalid && out_tready)) begin
      stall_cycles <= 0;
    end else if (stall_cycles == WATCHDOG_LIMIT) begin
      $display("RESULT: ERROR");
      $finish;
    end else begin
      stall_cycles <= stall_cycles + 1;
    end
  end

  initial begin
    int    hot [8];
    int    counted;
    int    pick;
    int    c;
    logic [FUNC_W-1:0] f;
    logic signed [FIELD_W-1:0] sat_b_re [4];
    logic signed [FIELD_W-1:0] sat_b_im [4];

    // reset state, DC channel, unused func, repeated channel back to back
    queue_item(FN_RDC, 0, S_MAX, S_MIN, S_MAX, S_MIN, 1'b0);
    queue_item(FN_RDC, 1023, '0, '0, '0, '0, 1'b0);
    queue_item(FN_RDT, 0, '0, '0, '0, '0, 1'b0);
    queue_item(FN_ACC, 0, S_MIN, S_MIN, S_MIN, S_MIN, 1'b0);
    queue_item(FN_RDC, 0, '0, '0, '0, '0, 1'b0);
    queue_item(FN_RDT, 0, '0, '0, '0, '0, 1'b0);
    queue_item(FN_ACC, 1, S_MAX, S_MAX, S_MAX, S_MAX, 1'b0);
    queue_item(FN_ACC, 1, S_MIN, S_MIN, S_MIN, S_MIN, 1'b0);
    queue_item(FN_ACC, 1023, S_MIN, S_MAX, S_MAX, S_MIN, 1'b0);
    queue_item(FN_UNUSED, 5, S_MAX, S_MAX, S_MIN, S_MIN, 1'b0);
    queue_item(FN_ACC, 7, S_MAX, S_MIN, S_MIN, S_MAX, 1'b0);
    queue_item(FN_ACC, 7, S_MIN, S_MAX, S_MAX, S_MAX, 1'b0);
    queue_item(FN_ACC, 7, 18'sd1, -18'sd1, 18'sd3, -18'sd2, 1'b0);
    queue_item(FN_RDC, 7, '0, '0, '0, '0, 1'b0);
    queue_item(FN_ACC, 7, S_MAX, '0, '0, S_MAX, 1'b0);
    queue_item(FN_RDC, 7, '0, '0, '0, '0, 1'b0);
    queue_item(FN_RDC, 1, '0, '0, '0, '0, 1'b0);
    queue_item(FN_RDC, 1, '0, '0, '0, '0, 1'b0);
    queue_item(FN_RDC, 1023, '0, '0, '0, '0, 1'b0);
    queue_item(FN_RDC, 5, '0, '0, '0, '0, 1'b0);
    queue_item(FN_RDT, 0, '0, '0, '0, '0, 1'b0);
    queue_item(FN_RDT, 0, '0, '0, '0, '0, 1'b0);

    // drive four channels hard, one sign per cross term
    sat_b_re = '{S_MIN, S_MAX, S_MIN, S_MAX};
    sat_b_im = '{S_MIN, S_MAX, S_MAX, S_MIN};
    for (int r = 0; r < SAT_ROUNDS; r++) begin
      for (int k = 0; k < 4; k++) begin
        queue_item(FN_ACC, 1000 + k, S_MIN, S_MIN, sat_b_re[k], sat_b_im[k],
                   r == 0 && k == 0);
      end
    end
    for (int k = 0; k < 8; k++) begin
      queue_item(FN_RDC, 1000 + (k % 4), '0, '0, '0, '0, 1'b0);
    end
    queue_item(FN_RDT, 0, '0, '0, '0, '0, 1'b0);

    hot[0] = 0;
    hot[1] = 1;
    hot[2] = 1023;
    for (int k = 3; k < 8; k++) hot[k] = $urandom_range(1, CHANNELS - 1);
    counted = 0;
    while (counted < RANDOM_ITEMS) begin
      pick = $urandom_range(0, 99);
      if (pick < 55) f = FN_ACC;
      else if (pick < 85) f = FN_RDC;
      else if (pick < 93) f = FN_RDT;
      else f = FN_UNUSED;
      if ($urandom_range(0, 3) != 0) c = hot[$urandom_range(0, 7)];
      else c = $urandom_range(0, CHANNELS - 1);
      queue_item(f, c, rand_sample(), rand_sample(), rand_sample(), rand_sample(),
                 counted == 0);
      if (f != FN_UNUSED && !(f == FN_ACC && c == 0)) counted++;
    end

    repeat (7) @(posedge clk);
    rst_n <= 1'b1;
    while (items_taken != items_total || sums_due.size() != 0) @(posedge clk);
    repeat (12) @(posedge clk);
    if (faults == 0) begin
      $display("RESULT: OK");
    end else begin
      $display("RESULT: ERROR");
    end
    $finish;
  end

endmodule
